>>> rtl/lpfp_pkg.sv
package lpfp_pkg;

   localparam int LEN_WIDTH = 16;            // declared length accumulator width, 4..32
   localparam int LEN_OUT_WIDTH = 16;        // body_length port width
   localparam int COUNT_WIDTH = 16;          // body byte counter width
   localparam int MAX_LEN_WIDTH = 16;        // max_body_length register width
   localparam int BYTE_WIDTH = 8;
   localparam int STATUS_WIDTH = 3;
   localparam int POS_WIDTH = 3;
   localparam int MARKER_LEN = 5;

   // wide enough for accum*10+9 and for every compare operand
   localparam int WIDE_WIDTH = (LEN_WIDTH + 4 > 16) ? LEN_WIDTH + 4 : 16;

   localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = '1;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO = "0";
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE = "9";

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_HEADER = 3'd0,
      ST_BODY   = 3'd1,
      ST_LAST   = 3'd2,
      ST_ERROR  = 3'd3,
      ST_EMPTY  = 3'd4
   } status_type;

   typedef struct packed {
      phase_type              phase;
      logic [POS_WIDTH-1:0]   marker_pos;
      logic [LEN_WIDTH-1:0]   length_accum;
      logic [COUNT_WIDTH-1:0] body_count;
   } state_type;

   typedef struct packed {
      status_type               status;
      logic [BYTE_WIDTH-1:0]    body_byte;
      logic [LEN_OUT_WIDTH-1:0] body_length;
      logic                     message_end;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_HUNT, marker_pos: '0, length_accum: '0, body_count: '0};

   function automatic logic [BYTE_WIDTH-1:0] marker_char(input logic [POS_WIDTH-1:0] pos);
      logic [BYTE_WIDTH-1:0] c;
      case (pos)
         3'd0: c = "S";
         3'd1: c = "T";
         3'd2: c = "A";
         3'd3: c = "R";
         3'd4: c = "T";
         default: c = CHAR_NEWLINE;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/lpfp_step.sv
module lpfp_step (
   input  lpfp_pkg::state_type                       cur,
   input  logic [lpfp_pkg::BYTE_WIDTH-1:0]           in_byte,
   input  logic [lpfp_pkg::MAX_LEN_WIDTH-1:0]        max_len,
   output lpfp_pkg::state_type                       nxt,
   output lpfp_pkg::result_type                      res
);

   localparam int W = lpfp_pkg::WIDE_WIDTH;

   logic         is_digit;
   logic         is_newline;
   logic [W-1:0] accum_wide;
   logic [W-1:0] accum_next;
   logic [W-1:0] count_wide;
   logic [W-1:0] max_wide;
   logic [lpfp_pkg::COUNT_WIDTH-1:0] count_inc;
   logic         error;

   assign is_digit   = (in_byte >= lpfp_pkg::CHAR_ZERO) && (in_byte <= lpfp_pkg::CHAR_NINE);
   assign is_newline = (in_byte == lpfp_pkg::CHAR_NEWLINE);
   assign accum_wide = W'(cur.length_accum);
   assign max_wide   = W'(max_len);
   // accum*10 + digit; '0' is 0x30 so the low nibble is the digit value
   assign accum_next = (accum_wide << 3) + (accum_wide << 1) + W'(in_byte[3:0]);
   assign count_inc  = cur.body_count + 1'b1;
   assign count_wide = W'(count_inc);

   always_comb begin
      nxt   = cur;
      error = 1'b0;
      res.status      = lpfp_pkg::ST_HEADER;
      res.body_byte   = '0;
      res.body_length = '0;
      res.message_end = 1'b0;

      case (cur.phase)
         lpfp_pkg::PH_LEN: begin
            if (is_digit) begin
               if (accum_next > max_wide || (accum_next >> lpfp_pkg::LEN_WIDTH) != '0) begin
                  error = 1'b1;
               end else begin
                  nxt.length_accum = accum_next[lpfp_pkg::LEN_WIDTH-1:0];
                  res.body_length  = accum_next[lpfp_pkg::LEN_OUT_WIDTH-1:0];
               end
            end else if (is_newline) begin
               res.body_length = accum_wide[lpfp_pkg::LEN_OUT_WIDTH-1:0];
               if (cur.length_accum == '0) begin
                  res.status      = lpfp_pkg::ST_EMPTY;
                  res.message_end = 1'b1;
                  nxt             = lpfp_pkg::STATE_RESET;
               end else begin
                  nxt.phase      = lpfp_pkg::PH_BODY;
                  nxt.body_count = '0;
               end
            end else begin
               error = 1'b1;
            end
         end
         lpfp_pkg::PH_BODY: begin
            res.body_byte   = in_byte;
            res.body_length = accum_wide[lpfp_pkg::LEN_OUT_WIDTH-1:0];
            if (count_wide >= accum_wide) begin
               res.status      = lpfp_pkg::ST_LAST;
               res.message_end = 1'b1;
               nxt             = lpfp_pkg::STATE_RESET;
            end else begin
               res.status     = lpfp_pkg::ST_BODY;
               nxt.body_count = count_inc;
            end
         end
         default: begin
            // marker hunt; the unused phase code lands here too
            if (cur.marker_pos < lpfp_pkg::POS_WIDTH'(lpfp_pkg::MARKER_LEN)) begin
               if (in_byte == lpfp_pkg::marker_char(cur.marker_pos)) begin
                  nxt.marker_pos = cur.marker_pos + 1'b1;
               end else begin
                  error = 1'b1;
               end
            end else if (is_newline) begin
               nxt.phase        = lpfp_pkg::PH_LEN;
               nxt.length_accum = '0;
            end else begin
               error = 1'b1;
            end
         end
      endcase

      if (error) begin
         res.status      = lpfp_pkg::ST_ERROR;
         res.body_byte   = '0;
         res.body_length = '0;
         res.message_end = 1'b1;
         nxt             = lpfp_pkg::STATE_RESET;
      end
   end

endmodule

>>> rtl/length_prefixed_frame_parser.sv
// A byte taken in at one edge is held in the input register; the combinational step then
// writes its result into the result register that drives rsp_, unless rsp_stall holds it.
// Throughput: one byte per cycle while the result is not stalled; the parse state is updated
// by a single combinational step between the input register and the result register.
// Reset (synchronous): marker hunt, counters cleared, no result pending,
// max_body_length back to 65535.
module length_prefixed_frame_parser (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lpfp_pkg::BYTE_WIDTH-1:0]       req_in_byte,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lpfp_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic [lpfp_pkg::BYTE_WIDTH-1:0]       rsp_body_byte,
   output logic [lpfp_pkg::LEN_OUT_WIDTH-1:0]    rsp_body_length,
   output logic                                  rsp_message_end,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lpfp_pkg::MAX_LEN_WIDTH-1:0]    csr_max_body_length
);

   logic                                   in_valid_ff;
   logic                                   in_valid_in;
   logic [lpfp_pkg::BYTE_WIDTH-1:0]        in_byte_ff;
   logic                                   out_valid_ff;
   lpfp_pkg::result_type                   out_ff;
   lpfp_pkg::state_type                    state_ff;
   lpfp_pkg::state_type                    state_in;
   lpfp_pkg::result_type                   res_in;
   logic [lpfp_pkg::MAX_LEN_WIDTH-1:0]     max_len_ff;
   logic                                   advance;

   // result register can take a new value when empty or being drained
   assign advance     = !out_valid_ff || !rsp_stall;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_valid && !req_stall;
   assign csr_ready   = 1'b1;

   lpfp_step u_step (
      .cur     (state_ff),
      .in_byte (in_byte_ff),
      .max_len (max_len_ff),
      .nxt     (state_in),
      .res     (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= lpfp_pkg::STATE_RESET;
         max_len_ff   <= lpfp_pkg::MAX_LEN_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= in_valid_in;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               state_ff <= state_in;
            end
         end
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_max_body_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && in_valid_ff) begin
         out_ff <= res_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_body_byte   = out_ff.body_byte;
   assign rsp_body_length = out_ff.body_length;
   assign rsp_message_end = out_ff.message_end;

`ifndef ASSERT_OFF
   a_end_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_message_end == (out_ff.status == lpfp_pkg::ST_LAST ||
                                        out_ff.status == lpfp_pkg::ST_ERROR ||
                                        out_ff.status == lpfp_pkg::ST_EMPTY))
      else $error("message_end disagrees with status");

   a_error_clears_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_ff.status == lpfp_pkg::ST_ERROR |->
         rsp_body_length == '0 && rsp_body_byte == '0)
      else $error("error result carries payload");

   a_body_needs_length: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == lpfp_pkg::PH_BODY |-> state_ff.length_accum != '0)
      else $error("body phase with zero declared length");

   a_marker_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.marker_pos <= lpfp_pkg::POS_WIDTH'(lpfp_pkg::MARKER_LEN))
      else $error("marker position past the marker");
`endif

endmodule

>>> sim/length_prefixed_frame_parser_test.sv
module length_prefixed_frame_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lpfp_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [8*MARKER_LEN-1:0] START_MARKER = "START";
   localparam logic [63:0] LEN_LIMIT = (64'd1 << LEN_WIDTH) - 64'd1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [BYTE_WIDTH-1:0]    req_in_byte = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic [BYTE_WIDTH-1:0]    rsp_body_byte;
   logic [LEN_OUT_WIDTH-1:0] rsp_body_length;
   logic                     rsp_message_end;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [MAX_LEN_WIDTH-1:0] csr_max_body_length = '0;

   length_prefixed_frame_parser uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_byte         (req_in_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_body_byte       (rsp_body_byte),
      .rsp_body_length     (rsp_body_length),
      .rsp_message_end     (rsp_message_end),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_body_length (csr_max_body_length)
   );

   // deframer state as predicted
   phase_type                parse_phase;
   logic [POS_WIDTH-1:0]     marker_seen;
   logic [LEN_WIDTH-1:0]     declared_len;
   logic [COUNT_WIDTH-1:0]   body_seen;
   logic [MAX_LEN_WIDTH-1:0] max_len;

   result_type expected_results[$];
   result_type front_result;

   bit idle_enable = 1'b1;
   bit hold_toggle = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   int failures = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int messages_done = 0;
   int empty_done = 0;
   int frames_dropped = 0;
   int config_writes = 0;
   int cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void restart_hunt();
      parse_phase = PH_HUNT;
      marker_seen = '0;
      declared_len = '0;
      body_seen = '0;
   endfunction

   function automatic result_type deframe_byte(input logic [BYTE_WIDTH-1:0] b);
      result_type r;
      logic [63:0] next_len;
      r.status = ST_HEADER;
      r.body_byte = '0;
      r.body_length = '0;
      r.message_end = 1'b0;
      case (parse_phase)
         PH_LEN: begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               next_len = declared_len * 64'd10 + (b - CHAR_ZERO);
               if (next_len > max_len || next_len > LEN_LIMIT) begin
                  r.status = ST_ERROR;
               end else begin
                  declared_len = next_len[LEN_WIDTH-1:0];
                  r.body_length = next_len[LEN_OUT_WIDTH-1:0];
               end
            end else if (b == CHAR_NEWLINE) begin
               r.body_length = declared_len;
               if (declared_len == 0) begin
                  r.status = ST_EMPTY;
                  r.message_end = 1'b1;
                  restart_hunt();
               end else begin
                  parse_phase = PH_BODY;
                  body_seen = '0;
               end
            end else begin
               r.status = ST_ERROR;
            end
         end
         PH_BODY: begin
            body_seen = body_seen + 1'b1;
            r.body_byte = b;
            r.body_length = declared_len;
            if (body_seen >= declared_len) begin
               r.status = ST_LAST;
               r.message_end = 1'b1;
               restart_hunt();
            end else begin
               r.status = ST_BODY;
            end
         end
         default: begin
            // an unused phase code behaves as the marker hunt
            if (marker_seen < MARKER_LEN) begin
               if (b == START_MARKER[8*MARKER_LEN-1-8*marker_seen -: 8])
                  marker_seen = marker_seen + 1'b1;
               else
                  r.status = ST_ERROR;
            end else if (b == CHAR_NEWLINE) begin
               parse_phase = PH_LEN;
               declared_len = '0;
            end else begin
               r.status = ST_ERROR;
            end
         end
      endcase
      if (r.status == ST_ERROR) begin
         r.message_end = 1'b1;
         r.body_length = '0;
         r.body_byte = '0;
         restart_hunt();
      end
      return r;
   endfunction

   // receiver: random stall bursts, plus a long hold when requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            stall_left = $urandom_range(0, 15);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer: status %0d", rsp_status);
            failures++;
         end else begin
            front_result = expected_results.pop_front();
            if (rsp_status !== front_result.status) begin
               $error("status: expected %0d, got %0d", front_result.status, rsp_status);
               failures++;
            end
            if (rsp_body_byte !== front_result.body_byte) begin
               $error("body_byte: expected %0d, got %0d", front_result.body_byte,
                      rsp_body_byte);
               failures++;
            end
            if (rsp_body_length !== front_result.body_length) begin
               $error("body_length: expected %0d, got %0d", front_result.body_length,
                      rsp_body_length);
               failures++;
            end
            if (rsp_message_end !== front_result.message_end) begin
               $error("message_end: expected %0d, got %0d", front_result.message_end,
                      rsp_message_end);
               failures++;
            end
         end
         case (rsp_status)
            ST_LAST:  messages_done++;
            ST_EMPTY: empty_done++;
            ST_ERROR: frames_dropped++;
            default: ;
         endcase
      end
   end

   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_in_byte = BYTE_WIDTH'($urandom_range(0, 255));
         repeat ($urandom_range(0, 15)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_in_byte = b;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      expected_results.push_back(deframe_byte(b));
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [MAX_LEN_WIDTH-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_max_body_length = value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      max_len = value;
      config_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one frame; a declared length over the limit gets only a few trailing bytes
   task automatic send_frame(input int unsigned len, input bit leading_zero,
                             input bit corrupt);
      logic [BYTE_WIDTH-1:0] frame_bytes[$];
      string digits;
      int unsigned body_n;
      int unsigned spot;
      int i;
      digits = $sformatf("%0d", len);
      if (leading_zero) digits = {"0", digits};
      if (len == 0 && $urandom_range(0, 2) == 0) digits = "";
      body_n = (len > max_len) ? $urandom_range(0, 3) : len;
      for (i = 0; i < MARKER_LEN; i++)
         frame_bytes.push_back(START_MARKER[8*MARKER_LEN-1-8*i -: 8]);
      frame_bytes.push_back(CHAR_NEWLINE);
      for (i = 0; i < digits.len(); i++) frame_bytes.push_back(digits[i]);
      frame_bytes.push_back(CHAR_NEWLINE);
      for (i = 0; i < body_n; i++)
         frame_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
      if (corrupt) begin
         spot = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[spot] = BYTE_WIDTH'($urandom_range(0, 255));
      end
      foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
   endtask

   task automatic test_directed_frames();
      send_text("START\n\n");               // empty message, no digits
      send_text("START\n2\n");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("STx");                     // wrong marker letter
      send_text("STARTS");                  // no newline after the marker
      send_text("START\n1z");               // non-digit in length
   endtask

   task automatic test_length_limits();
      send_text("START\n65535x");           // full 16-bit length, then dropped
      send_text("START\n65536");            // past the limit
      write_max_len('0);
      send_text("START\n1");
      send_text("START\n00\n");
      write_max_len(16'd3);
      send_text("START\n3\nabc");
      send_text("START\n4");
      send_text("START\n03\nxyz");
      write_max_len(MAX_LEN_RESET);
   endtask

   task automatic test_random_frames(input int frames, input logic [MAX_LEN_WIDTH-1:0] limit);
      int unsigned cap;
      int unsigned len;
      write_max_len(limit);
      repeat (frames) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 5)) send_byte(BYTE_WIDTH'($urandom_range(0, 255)));
         cap = (max_len < 24) ? max_len : 24;
         if ($urandom_range(0, 7) == 0)
            len = max_len + $urandom_range(1, 30);
         else
            len = $urandom_range(0, cap);
         send_frame(len, $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_toggle = ~hold_toggle;
      repeat (4) send_frame(20, 1'b0, 1'b0);
   endtask

   initial begin
      restart_hunt();
      max_len = MAX_LEN_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_frames();
      test_length_limits();
      test_random_frames(18, MAX_LEN_RESET);
      test_random_frames(10, MAX_LEN_WIDTH'($urandom_range(1, 20)));
      test_random_frames(10, MAX_LEN_WIDTH'($urandom_range(21, 400)));
      test_random_frames(4, '0);
      test_backpressure();
      idle_enable = 1'b0;
      test_random_frames(10, MAX_LEN_RESET);

      wait_idle();
      $display("%0d bytes in, %0d results checked: %0d messages, %0d empty, %0d dropped",
               bytes_sent, results_seen, messages_done, empty_done, frames_dropped);
      $display("%0d max_body_length writes, one long output hold", config_writes);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
